[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// clocked, reset-gated concurrent assertion shorthands
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain check with a fixed message
`define QESD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qesd assertion failed");

// check with a caller message
`define QESD_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

[rtl/qesd_pkg.sv]
// ----------------------------------------------------------------------------
// qesd_pkg
// shared types and constants of the encoder speed and direction meter
// ----------------------------------------------------------------------------
`default_nettype none

package qesd_pkg;

  // default parameter values
  localparam int TIME_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 8;

  // register widths
  localparam int TICK_RATE_W = 24;
  localparam int EPR_W       = 16;
  localparam int TIMEOUT_W   = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int SPEED_W     = 32;
  localparam int DIR_W       = 2;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register reset values
  localparam logic [TICK_RATE_W-1:0] TICK_RATE_RST    = TICK_RATE_W'(1000000);
  localparam logic [EPR_W-1:0]       EDGES_PER_REV_RST = EPR_W'(816);
  localparam logic [TIMEOUT_W-1:0]   STOP_TIMEOUT_RST = TIMEOUT_W'(100000);

  // register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_TICK_RATE     = 2'd0;
  localparam cfg_idx_t REG_EDGES_PER_REV = 2'd1;
  localparam cfg_idx_t REG_STOP_TIMEOUT  = 2'd2;

  // direction codes
  typedef logic [DIR_W-1:0] dir_t;
  localparam dir_t DIR_UNKNOWN = 2'd0;
  localparam dir_t DIR_FWD     = 2'd1;
  localparam dir_t DIR_REV     = 2'd2;

  // classified tick handed from front to back
  typedef struct packed {
    logic a_edge;
    logic timeout;
    dir_t dir;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/quadrature_encoder_speed_direction.sv]
// ----------------------------------------------------------------------------
// quadrature_encoder_speed_direction
// per-tick quadrature decoder with period-based speed measurement
// ----------------------------------------------------------------------------
// Each input transfer is one timer tick with the sampled levels of encoder
// channels A and B. Every tick gives exactly one result transfer holding the
// direction (0 unknown, 1 forward, 2 reverse), the speed in revolutions per
// second as unsigned fixed point with FRAC_BITS fraction bits (saturating at
// all ones), and a stopped flag that is set after reset and whenever more than
// stop_timeout ticks pass without an A edge. A tick with no A edge, or with an
// A edge whose divisor is zero, skips the divider; any other tick with an A
// edge goes through the single one-bit-per-cycle divider, which first
// divides tick_rate*2^FRAC_BITS by edges_per_rev and then divides that by the
// measured period. A two-entry queue sits between the tick classifier and the
// speed unit, so ticks keep being taken while a division runs and the result
// register waits, until the queue is full.
// Configuration writes are accepted at any time but must only be issued
// while the block is idle.
`default_nettype none

module quadrature_encoder_speed_direction
  import qesd_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // tick channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_pin_a,
  input  logic                  in_pin_b,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DIR_W-1:0]      out_turn_direction,
  output logic [SPEED_W-1:0]    out_speed,
  output logic                  out_stopped,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int Q_W = $bits(cmd_t) + TIME_WIDTH;

  // configuration registers
  logic [TICK_RATE_W-1:0] tick_rate_r;
  logic [EPR_W-1:0]       edges_per_rev_r;
  logic [TIMEOUT_W-1:0]   stop_timeout_r;

  // queue interface
  logic                  q_push, q_pop, q_full, q_not_empty;
  cmd_t                  push_cmd, pop_cmd;
  logic [TIME_WIDTH-1:0] push_period, pop_period;
  logic [Q_W-1:0]        q_rdata;

  assign cfg_ready = 1'b1;

  // writes to an index outside the register list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r     <= TICK_RATE_RST;
      edges_per_rev_r <= EDGES_PER_REV_RST;
      stop_timeout_r  <= STOP_TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TICK_RATE:     tick_rate_r     <= TICK_RATE_W'(cfg_wdata);
        REG_EDGES_PER_REV: edges_per_rev_r <= EPR_W'(cfg_wdata);
        REG_STOP_TIMEOUT:  stop_timeout_r  <= TIMEOUT_W'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // front: tick counting, edges, direction, timeout
  qesd_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pin_a     (in_pin_a),
    .in_pin_b     (in_pin_b),
    .stop_timeout (stop_timeout_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd),
    .q_period     (push_period)
  );

  // classified ticks waiting for the speed unit
  qesd_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     ({push_cmd, push_period}),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty)
  );

  assign pop_cmd    = q_rdata[Q_W-1 -: $bits(cmd_t)];
  assign pop_period = q_rdata[TIME_WIDTH-1:0];

  // back: division, timeout zeroing, result register
  qesd_back #(
    .TIME_WIDTH (TIME_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .tick_rate          (tick_rate_r),
    .edges_per_rev      (edges_per_rev_r),
    .q_not_empty        (q_not_empty),
    .q_pop              (q_pop),
    .q_cmd              (pop_cmd),
    .q_period           (pop_period),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_turn_direction (out_turn_direction),
    .out_speed          (out_speed),
    .out_stopped        (out_stopped)
  );

endmodule

`default_nettype wire

[rtl/qesd_fifo.sv]
// ----------------------------------------------------------------------------
// qesd_fifo
// short synchronous queue between tick classifier and speed unit
// ----------------------------------------------------------------------------
`default_nettype none

module qesd_fifo
  import qesd_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

[rtl/qesd_front.sv]
// ----------------------------------------------------------------------------
// qesd_front
// tick counter, edge detection, direction and timeout classification
// ----------------------------------------------------------------------------
`default_nettype none

module qesd_front
  import qesd_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_pin_a,
  input  logic                  in_pin_b,
  input  logic [TIMEOUT_W-1:0]  stop_timeout,
  input  logic                  q_full,
  output logic                  q_push,
  output cmd_t                  q_cmd,
  output logic [TIME_WIDTH-1:0] q_period
);

  localparam int CMP_W = (TIME_WIDTH > TIMEOUT_W) ? TIME_WIDTH : TIMEOUT_W;

  logic                  prev_a_r, prev_b_r;
  logic [TIME_WIDTH-1:0] tick_count_r, tick_count_nxt;
  logic [TIME_WIDTH-1:0] last_edge_r, last_edge_nxt;
  dir_t                  dir_r, dir_nxt;
  logic                  a_edge, b_edge;
  logic [TIME_WIDTH-1:0] elapsed;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    a_edge         = (in_pin_a != prev_a_r);
    b_edge         = (in_pin_b != prev_b_r);
    tick_count_nxt = tick_count_r + 1'b1;
    last_edge_nxt  = a_edge ? tick_count_nxt : last_edge_r;
    elapsed        = tick_count_nxt - last_edge_nxt;
    dir_nxt        = dir_r;
    if (a_edge) begin
      dir_nxt = (in_pin_a == in_pin_b) ? DIR_REV : DIR_FWD;
    end
    // b rule wins when both channels move in one tick
    if (b_edge) begin
      dir_nxt = (in_pin_a == in_pin_b) ? DIR_FWD : DIR_REV;
    end
    q_cmd.a_edge  = a_edge;
    q_cmd.timeout = CMP_W'(elapsed) > CMP_W'(stop_timeout);
    q_cmd.dir     = dir_nxt;
    q_period      = tick_count_nxt - last_edge_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r     <= 1'b1;
      prev_b_r     <= 1'b1;
      tick_count_r <= '0;
      last_edge_r  <= '0;
      dir_r        <= DIR_UNKNOWN;
    end else if (q_push) begin
      prev_a_r     <= in_pin_a;
      prev_b_r     <= in_pin_b;
      tick_count_r <= tick_count_nxt;
      last_edge_r  <= last_edge_nxt;
      dir_r        <= dir_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/qesd_div.sv]
// ----------------------------------------------------------------------------
// qesd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module qesd_div
  import qesd_pkg::*;
#(
  parameter int NUM_W = 32,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign done = done_r;
  assign quo  = quo_r;

  always_comb begin
    // dividend bits leave the top of quo_r as quotient bits enter below
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/qesd_back.sv]
// ----------------------------------------------------------------------------
// qesd_back
// speed computation, timeout zeroing and result register
// ----------------------------------------------------------------------------
`default_nettype none

module qesd_back
  import qesd_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [TICK_RATE_W-1:0] tick_rate,
  input  logic [EPR_W-1:0]       edges_per_rev,
  input  logic                   q_not_empty,
  output logic                   q_pop,
  input  cmd_t                   q_cmd,
  input  logic [TIME_WIDTH-1:0]  q_period,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dir_t                   out_turn_direction,
  output logic [SPEED_W-1:0]     out_speed,
  output logic                   out_stopped
);

  localparam int NUM_W = TICK_RATE_W + FRAC_BITS;
  localparam int EXT_W = (NUM_W > SPEED_W) ? NUM_W : SPEED_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_EPR,
    S_DIV_PER,
    S_OUT
  } state_t;

  state_t                state_r;
  cmd_t                  cmd_r;
  logic [TIME_WIDTH-1:0] period_r;
  logic [SPEED_W-1:0]    calc_r;
  logic [SPEED_W-1:0]    speed_r, speed_nxt;
  logic                  stop_r, stop_nxt;
  dir_t                  dir_r;
  logic                  valid_r;

  logic                  zero_div;
  logic                  div_start, div_done;
  logic [NUM_W-1:0]      div_num, div_quo;
  logic [TIME_WIDTH-1:0] div_den;
  logic [EXT_W-1:0]      quo_ext;
  logic [SPEED_W-1:0]    quo_sat;
  logic                  slot_free;

  assign out_valid          = valid_r;
  assign out_turn_direction = dir_r;
  assign out_speed          = speed_r;
  assign out_stopped        = stop_r;

  assign slot_free = !valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && q_not_empty;
  assign zero_div  = (edges_per_rev == '0) || (q_period == '0);

  always_comb begin
    div_start = ((state_r == S_IDLE) && q_not_empty && q_cmd.a_edge && !zero_div) ||
                ((state_r == S_DIV_EPR) && div_done);
    if (state_r == S_IDLE) begin
      div_num = NUM_W'(tick_rate) << FRAC_BITS;
      div_den = TIME_WIDTH'(edges_per_rev);
    end else begin
      div_num = div_quo;
      div_den = period_r;
    end
    quo_ext = EXT_W'(div_quo);
    quo_sat = (|(quo_ext >> SPEED_W)) ? '1 : quo_ext[SPEED_W-1:0];
    speed_nxt = speed_r;
    stop_nxt  = stop_r;
    if (cmd_r.a_edge) begin
      speed_nxt = calc_r;
      stop_nxt  = 1'b0;
    end
    if (cmd_r.timeout) begin
      speed_nxt = '0;
      stop_nxt  = 1'b1;
    end
  end

  qesd_div #(
    .NUM_W (NUM_W),
    .DEN_W (TIME_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      speed_r <= '0;
      stop_r  <= 1'b1;
      dir_r   <= DIR_UNKNOWN;
    end else begin
      if (valid_r && out_ready) begin
        valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_not_empty) begin
            cmd_r    <= q_cmd;
            period_r <= q_period;
            calc_r   <= '1;
            state_r  <= (q_cmd.a_edge && !zero_div) ? S_DIV_EPR : S_OUT;
          end
        end
        S_DIV_EPR: begin
          if (div_done) begin
            state_r <= S_DIV_PER;
          end
        end
        S_DIV_PER: begin
          if (div_done) begin
            calc_r  <= quo_sat;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            valid_r <= 1'b1;
            speed_r <= speed_nxt;
            stop_r  <= stop_nxt;
            dir_r   <= cmd_r.dir;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/qesd_checker.sv]
// ----------------------------------------------------------------------------
// qesd_checker
// port-level checks on the encoder meter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module qesd_checker
  import qesd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [DIR_W-1:0]   out_turn_direction,
  input  logic [SPEED_W-1:0] out_speed,
  input  logic               out_stopped
);

  // set once a known direction has been delivered
  logic seen_dir_r;

  // result fields held together for the stall check
  logic [DIR_W+SPEED_W:0] result_bus;
  logic                   out_stall;
  logic                   out_xfer;
  logic                   dir_due;
  logic                   dir_known;

  assign result_bus = {out_turn_direction, out_speed, out_stopped};
  assign out_stall  = out_valid && !out_ready;
  assign out_xfer   = out_valid && out_ready;
  assign dir_known  = (out_turn_direction != DIR_UNKNOWN);
  assign dir_due    = out_valid && seen_dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_dir_r <= 1'b0;
    end else if (out_xfer && dir_known) begin
      seen_dir_r <= 1'b1;
    end
  end

  `QESD_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(result_bus))
  `QESD_ASSERT(a_stopped_zero, clk, rst_n, out_valid && out_stopped |-> out_speed == '0)
  `QESD_ASSERT_MSG(a_dir_sticky, clk, rst_n, dir_due |-> dir_known, "direction lost")

endmodule

bind quadrature_encoder_speed_direction qesd_checker u_qesd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_turn_direction (out_turn_direction),
  .out_speed          (out_speed),
  .out_stopped        (out_stopped)
);

`default_nettype wire
